FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the queue RTL. Each macro expects signals
// named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)

`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/deq_pkg.sv
package deq_pkg;

    localparam int VALUE_W  = 64;
    localparam int OPCODE_W = 3;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Operation codes; the two unused codes behave as a query.
    localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_REVERSE    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic                empty_res;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

FILE: hw/rtl/deq_store.sv
module deq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  deq_pkg::mem_cmd_t  mem_cmd,
    input  logic [AW-1:0]      wr_addr,
    input  logic [WIDTH-1:0]   wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic [WIDTH-1:0]   rd_data
);
    import deq_pkg::*;

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_cmd.wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    // Read data only changes when a read is issued, so it holds while the
    // result waits.
    always_ff @(posedge clk)
    begin
        if (mem_cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/deq_ctrl.sv
`include "assert_macros.svh"

module deq_ctrl #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  deq_pkg::cmd_t      cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output deq_pkg::rsp_t      res,
    output deq_pkg::mem_cmd_t  mem_cmd,
    output logic [AW-1:0]      wr_addr,
    output logic [WIDTH-1:0]   wr_data,
    output logic [AW-1:0]      rd_addr,
    input  logic [WIDTH-1:0]   rd_data
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              rev_reg, rev_next;
    logic              fill_low_reg, fill_low_next;
    logic              fill_high_reg, fill_high_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WIDTH-1:0]  low_reg, low_next;
    logic [WIDTH-1:0]  high_reg, high_next;

    logic [WIDTH-1:0]  val;
    logic [AW-1:0]     head_inc, head_dec, tail_inc, tail_dec;
    logic              is_empty, is_full, at_low;
    logic [WIDTH-1:0]  low_eff, high_eff;
    logic [WIDTH-1:0]  front_w, back_w;
    logic [VALUE_W+WIDTH-1:0] front_ext, back_ext;
    logic [CW+COUNT_W-1:0]    count_ext;

    assign val      = cmd.value[WIDTH-1:0];
    assign head_inc = (head_reg == LAST_C) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_C : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_C) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_C : tail_reg - 1'b1;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_C);

    // The end values are cached; a pop refreshes the new end from the store.
    assign low_eff  = fill_low_reg  ? rd_data : low_reg;
    assign high_eff = fill_high_reg ? rd_data : high_reg;

    assign cmd_ready = (state_reg == S_IDLE);
    assign wr_data   = val;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        fill_low_next  = fill_low_reg;
        fill_high_next = fill_high_reg;
        status_next    = status_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mem_cmd        = '0;
        wr_addr        = '0;
        rd_addr        = '0;
        at_low         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next     = S_FILL;
                    status_next    = ST_OK;
                    fill_low_next  = 1'b0;
                    fill_high_next = 1'b0;
                    case (cmd.opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            at_low = (cmd.opcode == OP_PUSH_FRONT) != rev_reg;
                            if (is_full)
                            begin
                                status_next = ST_PUSH_FULL;
                            end
                            else
                            begin
                                mem_cmd.wr_en = 1'b1;
                                count_next    = count_reg + 1'b1;
                                if (at_low)
                                begin
                                    head_next = head_dec;
                                    wr_addr   = head_dec;
                                    low_next  = val;
                                    if (is_empty)
                                    begin
                                        high_next = val;
                                    end
                                end
                                else
                                begin
                                    tail_next = tail_inc;
                                    wr_addr   = tail_inc;
                                    high_next = val;
                                    if (is_empty)
                                    begin
                                        low_next = val;
                                    end
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            at_low = (cmd.opcode == OP_POP_FRONT) != rev_reg;
                            if (is_empty)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                mem_cmd.rd_en = 1'b1;
                                count_next    = count_reg - 1'b1;
                                if (at_low)
                                begin
                                    head_next     = head_inc;
                                    rd_addr       = head_inc;
                                    fill_low_next = 1'b1;
                                end
                                else
                                begin
                                    tail_next      = tail_dec;
                                    rd_addr        = tail_dec;
                                    fill_high_next = 1'b1;
                                end
                            end
                        end
                        OP_REVERSE:
                        begin
                            rev_next = !rev_reg;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                low_next       = low_eff;
                high_next      = high_eff;
                fill_low_next  = 1'b0;
                fill_high_next = 1'b0;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= LAST_C;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            fill_low_reg  <= 1'b0;
            fill_high_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            fill_low_reg  <= fill_low_next;
            fill_high_reg <= fill_high_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
    end

    assign front_w   = rev_reg ? high_eff : low_eff;
    assign back_w    = rev_reg ? low_eff : high_eff;
    assign front_ext = {{VALUE_W{1'b0}}, front_w};
    assign back_ext  = {{VALUE_W{1'b0}}, back_w};
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    assign res_valid       = (state_reg == S_FILL);
    assign res.front_value = is_empty ? '0 : front_ext[VALUE_W-1:0];
    assign res.back_value  = is_empty ? '0 : back_ext[VALUE_W-1:0];
    assign res.empty_res   = is_empty;
    assign res.count       = count_ext[COUNT_W-1:0];
    assign res.status      = status_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_C, "entry count beyond depth")
    `ASSERT_IMPLIES(a_no_write_full, mem_cmd.wr_en, !is_full, "store written while full")
    `ASSERT_NEXT(a_read_then_fill, mem_cmd.rd_en, (state_reg == S_FILL) && (fill_low_reg || fill_high_reg), "store read without refresh of an end")
    `ASSERT_NEXT(a_res_holds, res_valid && !res_ready, res_valid && $stable(res), "pending result changed")

endmodule

FILE: hw/rtl/double_ended_queue_core.sv
// Bounded double-ended queue of WIDTH-bit words held in a ring store of
// DEPTH entries. Each command beat carries one operation (query, push front,
// push back, pop front, pop back or reverse) and produces exactly one
// response beat with the front and back values, the empty flag, the entry
// count and a status: a pop on an empty queue is reported and ignored, and a
// push on a full queue is reported and dropped. Reverse only flips a
// direction flag, so it costs the same as any other operation. Pushed words
// are truncated to WIDTH bits and returned zero-extended; the count field is
// five bits wide and wraps when DEPTH is larger than that can hold. Each
// operation passes S_IDLE, which on acceptance updates the pointers and
// issues at most one store access, and then S_FILL, which waits for the
// registered read data of the store that a pop needs to learn the value
// that becomes the new end. Commands are taken only in S_IDLE, so a new one
// waits until the last leaves S_FILL. A response held in the output register
// does not stop the next command from being accepted; only a second
// pending response stalls the queue. No clearing pass is needed after reset.
module double_ended_queue_core #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  deq_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output deq_pkg::rsp_t  rsp
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    mem_cmd_t         mem_cmd;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;
    logic [AW-1:0]    rd_addr;
    logic [WIDTH-1:0] rd_data;

    logic             res_valid;
    logic             res_ready;
    rsp_t             res;

    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg;

    // The ring store: one write port and one registered read port.
    deq_store #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .mem_cmd (mem_cmd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pointer, count and end-value bookkeeping.
    deq_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_cmd   (mem_cmd),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // The output register takes a new response whenever it is empty or its
    // current beat is being taken in the same cycle.
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
